// ----- hdl/hrrn_pkg.sv -----
// ---------------------------------------------------------------------------
// hrrn_pkg
// Shared types, codes and reset constants of the HRRN scheduler.
// ---------------------------------------------------------------------------
package hrrn_pkg;

  localparam int DEF_READY_DEPTH   = 8;
  localparam int DEF_BLOCKED_DEPTH = 8;

  localparam logic [5:0]  RESET_FREE    = 6'd10;
  localparam logic [3:0]  RESET_QUANTUM = 4'd3;
  localparam logic [5:0]  FREE_MAX      = 6'd63;
  localparam logic [15:0] WAIT_MAX      = 16'hFFFF;

  // operation codes
  localparam logic [1:0] OP_CREATE = 2'd0;
  localparam logic [1:0] OP_RUN    = 2'd1;
  localparam logic [1:0] OP_BLOCK  = 2'd2;
  localparam logic [1:0] OP_IO     = 2'd3;

  // register indexes
  localparam logic [1:0] CFG_TOTAL_A = 2'd0;
  localparam logic [1:0] CFG_TOTAL_B = 2'd1;
  localparam logic [1:0] CFG_TOTAL_C = 2'd2;
  localparam logic [1:0] CFG_QUANTUM = 2'd3;

  // status codes
  localparam logic [3:0] ST_CREATED     = 4'd0;
  localparam logic [3:0] ST_NO_RES      = 4'd1;
  localparam logic [3:0] ST_FULL        = 4'd2;
  localparam logic [3:0] ST_RAN         = 4'd3;
  localparam logic [3:0] ST_FINISHED    = 4'd4;
  localparam logic [3:0] ST_REQUEUED    = 4'd5;
  localparam logic [3:0] ST_YIELDED     = 4'd6;
  localparam logic [3:0] ST_IDLE_IO     = 4'd7;
  localparam logic [3:0] ST_IDLE_EMPTY  = 4'd8;
  localparam logic [3:0] ST_BLOCKED     = 4'd9;
  localparam logic [3:0] ST_NOT_RUNNING = 4'd10;
  localparam logic [3:0] ST_IO_DONE     = 4'd11;
  localparam logic [3:0] ST_NONE_BLOCK  = 4'd12;

  // one process table entry
  typedef struct packed {
    logic [7:0]       id;
    logic [7:0]       exec;
    logic [15:0]      wait_cnt;
    logic [2:0][3:0]  need;
    logic [2:0][3:0]  alloc;
    logic [7:0]       ticks;
  } entry_t;

endpackage

// ----- hdl/hrrn_ram.sv -----
// ---------------------------------------------------------------------------
// hrrn_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module hrrn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/hrrn_scheduler_with_resources.sv -----
// ---------------------------------------------------------------------------
// hrrn_scheduler_with_resources
// Single-CPU highest-response-ratio-next scheduler with three resource pools.
// ---------------------------------------------------------------------------
//
//  channel  | signals                                   | transfer
//  ---------+-------------------------------------------+----------------------
//  command  | start, busy, op, proc_id, exec_time, ...  | start & !busy
//  result   | done, status, affected_id, ...            | done (one cycle)
//  config   | psel, penable, pwrite, paddr, pwdata, ... | APB access, no wait
//
//  Create and block complete in the accepting cycle: done follows the next cycle.
//  Run walks the ready RAM one entry a cycle (registered read data): a dispatch
//  scan when nothing runs, an aging/compaction sweep when entries wait, and a
//  commit state.
//  IO tick walks the blocked RAM once.
//  Reset is synchronous; no clearing pass, the fill counts mark live entries.
//  The result receiver cannot stall; every result shows for one cycle.
// ---------------------------------------------------------------------------
module hrrn_scheduler_with_resources #(
  parameter int READY_DEPTH   = hrrn_pkg::DEF_READY_DEPTH,
  parameter int BLOCKED_DEPTH = hrrn_pkg::DEF_BLOCKED_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  // command
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  op,
  input  logic [7:0]  proc_id,
  input  logic [7:0]  exec_time,
  input  logic [3:0]  need_a,
  input  logic [3:0]  need_b,
  input  logic [3:0]  need_c,
  input  logic [7:0]  block_ticks,
  // result
  output logic        done,
  output logic [3:0]  status,
  output logic [7:0]  affected_id,
  output logic        running_valid,
  output logic [7:0]  running_id,
  output logic [3:0]  ready_count,
  output logic [3:0]  blocked_count,
  output logic [3:0]  released_count,
  output logic [5:0]  free_a,
  output logic [5:0]  free_b,
  output logic [5:0]  free_c,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  import hrrn_pkg::*;

  localparam int RIW = $clog2(READY_DEPTH);
  localparam int RCW = $clog2(READY_DEPTH + 1);
  localparam int BIW = $clog2(BLOCKED_DEPTH);
  localparam int BCW = $clog2(BLOCKED_DEPTH + 1);
  localparam int EW  = $bits(entry_t);

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_SWEEP, S_FIN, S_IO} state_t;

  state_t         state;
  logic [5:0]     free [3];
  logic [5:0]     total [3];
  logic [3:0]     quantum;
  logic [3:0]     slice_cnt;
  entry_t         run_e;
  logic [RCW-1:0] ready_n;
  logic [BCW-1:0] blocked_n;
  logic [RCW-1:0] r_idx;
  logic [BCW-1:0] b_idx;
  logic           pend;
  logic [RIW-1:0] pend_r_idx;
  logic [BIW-1:0] pend_b_idx;
  logic [RCW-1:0] dst_r;
  logic [BCW-1:0] dst_b;
  logic [RIW-1:0] best_idx;
  entry_t         best_e;
  logic           skip;
  logic           first;
  logic [BCW-1:0] rel_cnt;

  // ready and blocked RAMs
  logic           r_we, b_we;
  logic [RIW-1:0] r_waddr;
  logic [BIW-1:0] b_waddr;
  entry_t         r_wdata, b_wdata, r_rdata, b_rdata;
  logic [EW-1:0]  r_rraw, b_rraw;

  hrrn_ram #(.WIDTH(EW), .DEPTH(READY_DEPTH)) u_ready_ram (
    .clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
    .raddr(r_idx[RIW-1:0]), .rdata(r_rraw)
  );

  hrrn_ram #(.WIDTH(EW), .DEPTH(BLOCKED_DEPTH)) u_blocked_ram (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
    .raddr(b_idx[BIW-1:0]), .rdata(b_rraw)
  );

  assign r_rdata = entry_t'(r_rraw);
  assign b_rdata = entry_t'(b_rraw);

  assign busy           = (state != S_IDLE);
  assign pready         = 1'b1;
  assign running_id     = running_valid ? run_e.id : 8'd0;
  assign ready_count    = 4'(ready_n);
  assign blocked_count  = 4'(blocked_n);
  assign free_a         = free[0];
  assign free_b         = free[1];
  assign free_c         = free[2];

  // config port
  logic       cfg_we;
  logic [1:0] cfg_idx;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = paddr[3:2];

  always_comb begin
    case (cfg_idx)
      CFG_TOTAL_A: prdata = {26'd0, total[0]};
      CFG_TOTAL_B: prdata = {26'd0, total[1]};
      CFG_TOTAL_C: prdata = {26'd0, total[2]};
      CFG_QUANTUM: prdata = {28'd0, quantum};
      default:     prdata = 32'd0;
    endcase
  end

  // table fill flags
  logic ready_full, blocked_full;
  assign ready_full   = (ready_n >= RCW'(READY_DEPTH));
  assign blocked_full = (blocked_n >= BCW'(BLOCKED_DEPTH));

  // create
  logic   create_nores;
  entry_t create_e;
  always_comb begin
    create_nores  = (free[0] == 6'd0) || (free[1] == 6'd0) || (free[2] == 6'd0);
    create_e      = '0;
    create_e.id   = proc_id;
    create_e.exec = (exec_time == 8'd0) ? 8'd1 : exec_time;
    create_e.need[0] = (need_a != 4'd0) ? need_a - 4'd1 : 4'd0;
    create_e.need[1] = (need_b != 4'd0) ? need_b - 4'd1 : 4'd0;
    create_e.need[2] = (need_c != 4'd0) ? need_c - 4'd1 : 4'd0;
    create_e.alloc[0] = 4'd1;
    create_e.alloc[1] = 4'd1;
    create_e.alloc[2] = 4'd1;
  end

  entry_t block_e;
  always_comb begin
    block_e       = run_e;
    block_e.ticks = (block_ticks == 8'd0) ? 8'd1 : block_ticks;
  end

  // dispatch compare: strictly higher ratio, by cross-multiplication
  logic [16:0] c_sum, b_sum;
  logic [24:0] lhs, rhs;
  logic        take;
  logic        r_last;
  entry_t      best_next;
  logic [RIW-1:0] best_idx_next;
  always_comb begin
    c_sum = 17'(r_rdata.wait_cnt) + 17'(r_rdata.exec);
    b_sum = 17'(best_e.wait_cnt) + 17'(best_e.exec);
    lhs   = 25'(c_sum) * 25'(best_e.exec);
    rhs   = 25'(b_sum) * 25'(r_rdata.exec);
    take  = (pend_r_idx == '0) || (lhs > rhs);
    best_next     = take ? r_rdata : best_e;
    best_idx_next = take ? pend_r_idx : best_idx;
    r_last = pend && (RCW'(pend_r_idx) == ready_n - RCW'(1));
  end

  // aging of a swept ready entry
  logic   sweep_keep;
  entry_t aged_e;
  always_comb begin
    sweep_keep = !(skip && (pend_r_idx == best_idx));
    aged_e     = r_rdata;
    if (r_rdata.wait_cnt != WAIT_MAX) begin
      aged_e.wait_cnt = r_rdata.wait_cnt + 16'd1;
    end
  end

  // commit of one run slice
  logic       grant;
  entry_t     ent_y, ent_g;
  logic [5:0] free_g [3];
  logic [5:0] free_rel [3];
  logic [6:0] rel_sum [3];
  logic [3:0] sc_inc, q_eff;
  logic       expire, fin_done;
  always_comb begin
    grant = 1'b1;
    ent_y = run_e;
    ent_y.wait_cnt = 16'd0;
    ent_g = ent_y;
    for (int r = 0; r < 3; r++) begin
      if (free[r] < 6'(run_e.need[r])) begin
        grant = 1'b0;
      end
      ent_g.alloc[r] = run_e.alloc[r] + run_e.need[r];
      ent_g.need[r]  = 4'd0;
      free_g[r]      = free[r] - 6'(run_e.need[r]);
      rel_sum[r]     = 7'(free_g[r]) + 7'(ent_g.alloc[r]);
      free_rel[r]    = (rel_sum[r] > 7'(FREE_MAX)) ? FREE_MAX : rel_sum[r][5:0];
    end
    if (run_e.exec != 8'd0) begin
      ent_g.exec = run_e.exec - 8'd1;
    end
    fin_done = (ent_g.exec == 8'd0);
    sc_inc   = slice_cnt + 4'd1;
    q_eff    = (quantum == 4'd0) ? 4'd1 : quantum;
    expire   = (sc_inc >= q_eff);
  end

  logic fin_push;
  assign fin_push = !ready_full && (!grant || (!fin_done && expire));

  // io tick decision on the swept blocked entry
  logic [7:0] io_t;
  logic       io_rel, b_last;
  entry_t     io_keep_e, io_rel_e;
  always_comb begin
    io_t   = (b_rdata.ticks != 8'd0) ? b_rdata.ticks - 8'd1 : 8'd0;
    io_rel = (io_t == 8'd0) && !ready_full;
    io_rel_e       = b_rdata;
    io_rel_e.ticks = io_t;
    io_keep_e       = b_rdata;
    io_keep_e.ticks = (io_t == 8'd0) ? 8'd1 : io_t;
    b_last = pend && (BCW'(pend_b_idx) == blocked_n - BCW'(1));
  end

  // RAM write ports
  always_comb begin
    r_we    = 1'b0;
    r_waddr = ready_n[RIW-1:0];
    r_wdata = create_e;
    b_we    = 1'b0;
    b_waddr = blocked_n[BIW-1:0];
    b_wdata = block_e;
    case (state)
      S_IDLE: begin
        if (start && op == OP_CREATE && !create_nores && !ready_full) begin
          r_we = 1'b1;
        end
        if (start && op == OP_BLOCK && running_valid && !blocked_full) begin
          b_we = 1'b1;
        end
      end
      S_SWEEP: begin
        r_we    = pend && sweep_keep;
        r_waddr = dst_r[RIW-1:0];
        r_wdata = aged_e;
      end
      S_FIN: begin
        r_we    = fin_push;
        r_wdata = grant ? ent_g : ent_y;
      end
      S_IO: begin
        r_we    = pend && io_rel;
        r_wdata = io_rel_e;
        b_we    = pend && !io_rel;
        b_waddr = dst_b[BIW-1:0];
        b_wdata = io_keep_e;
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      done          <= 1'b0;
      running_valid <= 1'b0;
      slice_cnt     <= 4'd0;
      ready_n       <= '0;
      blocked_n     <= '0;
      pend          <= 1'b0;
      quantum       <= RESET_QUANTUM;
      for (int r = 0; r < 3; r++) begin
        free[r]  <= RESET_FREE;
        total[r] <= RESET_FREE;
      end
    end else begin
      done <= 1'b0;

      // configuration writes must arrive only while idle; the block does not enforce it
      if (cfg_we) begin
        case (cfg_idx)
          CFG_TOTAL_A: begin total[0] <= pwdata[5:0]; free[0] <= pwdata[5:0]; end
          CFG_TOTAL_B: begin total[1] <= pwdata[5:0]; free[1] <= pwdata[5:0]; end
          CFG_TOTAL_C: begin total[2] <= pwdata[5:0]; free[2] <= pwdata[5:0]; end
          CFG_QUANTUM: quantum <= pwdata[3:0];
          default: ;
        endcase
      end

      case (state)
        S_IDLE: begin
          if (start) begin
            released_count <= 4'd0;
            affected_id    <= 8'd0;
            case (op)
              OP_CREATE: begin
                done <= 1'b1;
                if (create_nores) begin
                  status <= ST_NO_RES;
                end else if (ready_full) begin
                  status <= ST_FULL;
                end else begin
                  status      <= ST_CREATED;
                  affected_id <= proc_id;
                  ready_n     <= ready_n + RCW'(1);
                  for (int r = 0; r < 3; r++) begin
                    free[r] <= free[r] - 6'd1;
                  end
                end
              end
              OP_RUN: begin
                r_idx <= '0;
                pend  <= 1'b0;
                dst_r <= '0;
                if (!running_valid) begin
                  if (ready_n == '0) begin
                    done   <= 1'b1;
                    status <= (blocked_n != '0) ? ST_IDLE_IO : ST_IDLE_EMPTY;
                  end else begin
                    skip  <= 1'b1;
                    state <= S_SCAN;
                  end
                end else begin
                  skip  <= 1'b0;
                  // nothing to age: go straight to the commit
                  state <= (ready_n == '0) ? S_FIN : S_SWEEP;
                end
              end
              OP_BLOCK: begin
                done <= 1'b1;
                if (!running_valid) begin
                  status <= ST_NOT_RUNNING;
                end else begin
                  affected_id <= run_e.id;
                  if (blocked_full) begin
                    status <= ST_FULL;
                  end else begin
                    status        <= ST_BLOCKED;
                    blocked_n     <= blocked_n + BCW'(1);
                    running_valid <= 1'b0;
                  end
                end
              end
              default: begin
                if (blocked_n == '0) begin
                  done   <= 1'b1;
                  status <= ST_NONE_BLOCK;
                end else begin
                  b_idx   <= '0;
                  pend    <= 1'b0;
                  dst_b   <= '0;
                  rel_cnt <= '0;
                  first   <= 1'b1;
                  state   <= S_IO;
                end
              end
            endcase
          end
        end

        // find the best ready entry, oldest wins ties
        S_SCAN: begin
          pend       <= (r_idx < ready_n);
          pend_r_idx <= r_idx[RIW-1:0];
          if (r_idx < ready_n) begin
            r_idx <= r_idx + RCW'(1);
          end
          if (pend) begin
            best_e   <= best_next;
            best_idx <= best_idx_next;
          end
          if (r_last) begin
            run_e         <= best_next;
            running_valid <= 1'b1;
            r_idx         <= '0;
            pend          <= 1'b0;
            state         <= S_SWEEP;
          end
        end

        // age every ready entry, drop one dispatched by this run, compact in place
        S_SWEEP: begin
          pend       <= (r_idx < ready_n);
          pend_r_idx <= r_idx[RIW-1:0];
          if (r_idx < ready_n) begin
            r_idx <= r_idx + RCW'(1);
          end
          if (pend && sweep_keep) begin
            dst_r <= dst_r + RCW'(1);
          end
          if (r_last) begin
            ready_n <= dst_r + (sweep_keep ? RCW'(1) : RCW'(0));
            pend    <= 1'b0;
            state   <= S_FIN;
          end
        end

        S_FIN: begin
          done        <= 1'b1;
          affected_id <= run_e.id;
          state       <= S_IDLE;
          if (fin_push) begin
            ready_n <= ready_n + RCW'(1);
          end
          if (!grant) begin
            run_e <= ent_y;
            if (ready_full) begin
              status <= ST_FULL;
            end else begin
              status        <= ST_YIELDED;
              running_valid <= 1'b0;
            end
          end else begin
            run_e     <= ent_g;
            slice_cnt <= expire ? 4'd0 : sc_inc;
            for (int r = 0; r < 3; r++) begin
              free[r] <= fin_done ? free_rel[r] : free_g[r];
            end
            if (fin_done) begin
              status        <= ST_FINISHED;
              running_valid <= 1'b0;
            end else if (expire) begin
              if (ready_full) begin
                status <= ST_FULL;
              end else begin
                status        <= ST_REQUEUED;
                running_valid <= 1'b0;
              end
            end else begin
              status <= ST_RAN;
            end
          end
        end

        // count down blocked entries, release expired ones while room lasts
        S_IO: begin
          pend       <= (b_idx < blocked_n);
          pend_b_idx <= b_idx[BIW-1:0];
          if (b_idx < blocked_n) begin
            b_idx <= b_idx + BCW'(1);
          end
          if (pend) begin
            if (io_rel) begin
              ready_n <= ready_n + RCW'(1);
              rel_cnt <= rel_cnt + BCW'(1);
              first   <= 1'b0;
              if (first) begin
                affected_id <= b_rdata.id;
              end
            end else begin
              dst_b <= dst_b + BCW'(1);
            end
          end
          if (b_last) begin
            blocked_n      <= dst_b + (io_rel ? BCW'(0) : BCW'(1));
            released_count <= 4'(rel_cnt + (io_rel ? BCW'(1) : BCW'(0)));
            status         <= ST_IO_DONE;
            done           <= 1'b1;
            pend           <= 1'b0;
            state          <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy || start))
    else $error("result strobe without a transaction in flight");

  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted transaction neither busy nor finished");

  a_ready_bound: assert property (@(posedge clk) disable iff (rst)
    ready_n <= RCW'(READY_DEPTH))
    else $error("ready count beyond table depth");

  a_blocked_bound: assert property (@(posedge clk) disable iff (rst)
    blocked_n <= BCW'(BLOCKED_DEPTH))
    else $error("blocked count beyond table depth");

endmodule
